/* rtl/smt_pkg.sv */
// ----------------------------------------------------------------------------
// smt_pkg: shared types and codes for the sorted multiset table
// Request and response item layouts, action and status codes.
// ----------------------------------------------------------------------------
package smt_pkg;

  localparam int ACTION_W = 2;
  localparam int FIELD_W  = 32;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 2;

  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_FIND   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;

  typedef struct packed {
    logic [ACTION_W-1:0]       action;
    logic signed [FIELD_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic                found;
    logic [COUNT_W-1:0]  count;
    logic [STATUS_W-1:0] status;
  } rsp_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins_go;
    logic rem_go;
  } cell_ctrl_t;

endpackage

/* rtl/sorted_multiset_table_top.sv */
// ----------------------------------------------------------------------------
// sorted_multiset_table_top: sorted multiset of signed values
// Row of compare-and-shift cells with a response register on the output.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req) carries one item: an action
//   (insert, find, remove one instance) and a signed value.
//   rsp channel (rsp_valid / rsp_stall / rsp) returns one item per request:
//   found flag, entry count after the action, and status.
//   Every cell compares its entry with the key in parallel; the cells past the
//   insert or remove point shift by one slot in the same cycle. One item is
//   taken per cycle unless stalled, with its response in the next cycle.
//   The response register is the only buffer: while rsp is held by
//   rsp_stall, req_stall is raised and no new item is taken.
//   Reset clears the entry count and the response valid; cell contents are
//   left as they are and only slots below the count are ever looked at.
//   An insert into a full table and a remove of an absent value leave the
//   table unchanged and report it in status.
// ----------------------------------------------------------------------------
module sorted_multiset_table_top #(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  smt_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output smt_pkg::rsp_t rsp
);
  import smt_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic                          accept;
  logic [CW-1:0]                 cnt;
  logic [CW-1:0]                 cnt_next;
  logic signed [VALUE_WIDTH-1:0] key;
  logic [VALUE_WIDTH+FIELD_W-1:0] key_wide;
  logic [CW+COUNT_W-1:0]         cnt_wide;
  logic                          full;
  logic                          found;
  logic [STATUS_W-1:0]           status;
  cell_ctrl_t                    ctrl;

  logic signed [VALUE_WIDTH-1:0] entries [CAPACITY];
  logic [CAPACITY-1:0]           le;
  logic [CAPACITY-1:0]           eq;

  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  // low VALUE_WIDTH bits of the field, sign-extended if the store is wider
  assign key_wide = {{VALUE_WIDTH{req.value[FIELD_W-1]}}, req.value};
  assign key      = key_wide[VALUE_WIDTH-1:0];

  assign full  = (cnt == CW'(CAPACITY));
  assign found = |eq;

  assign ctrl.ins_go = accept && (req.action == ACT_INSERT) && !full;
  assign ctrl.rem_go = accept && (req.action == ACT_REMOVE) && found;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                          left_le;
    logic signed [VALUE_WIDTH-1:0] left_entry;
    logic signed [VALUE_WIDTH-1:0] right_entry;

    if (i == 0) begin : g_first
      assign left_le    = 1'b1;
      assign left_entry = key;
    end else begin : g_mid
      assign left_le    = le[i-1];
      assign left_entry = entries[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_entry = entries[i];
    end else begin : g_inner
      assign right_entry = entries[i+1];
    end

    smt_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (CW'(i) < cnt),
      .key        (key),
      .left_le    (left_le),
      .left_entry (left_entry),
      .right_entry(right_entry),
      .entry      (entries[i]),
      .le         (le[i]),
      .eq         (eq[i])
    );
  end

  always_comb begin
    cnt_next = cnt;
    status   = ST_DONE;
    case (req.action)
      ACT_INSERT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          cnt_next = cnt + CW'(1);
        end
      end
      ACT_REMOVE: begin
        if (found) begin
          cnt_next = cnt - CW'(1);
        end else begin
          status = ST_MISS;
        end
      end
      default: begin
      end
    endcase
  end

  assign cnt_wide = {{COUNT_W{1'b0}}, cnt_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        cnt       <= cnt_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.found  <= found;
      rsp.count  <= cnt_wide[COUNT_W-1:0];
      rsp.status <= status;
    end
  end

endmodule

/* rtl/smt_cell.sv */
// ----------------------------------------------------------------------------
// smt_cell: one slot of the sorted table
// Holds one entry, compares it with the broadcast key and shifts toward the
// right neighbor on insert or takes the right neighbor's entry on remove.
// ----------------------------------------------------------------------------
module smt_cell #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  smt_pkg::cell_ctrl_t           ctrl,
  input  logic                          occupied,
  input  logic signed [VALUE_WIDTH-1:0] key,
  input  logic                          left_le,
  input  logic signed [VALUE_WIDTH-1:0] left_entry,
  input  logic signed [VALUE_WIDTH-1:0] right_entry,
  output logic signed [VALUE_WIDTH-1:0] entry,
  output logic                          le,
  output logic                          eq
);
  import smt_pkg::*;

  logic lt;

  assign le = occupied && (entry <= key);
  assign eq = occupied && (entry == key);
  assign lt = le && !eq;

  always_ff @(posedge clk) begin
    if (ctrl.ins_go && !le) begin
      // first cell past the insert point takes the key, the rest shift right
      entry <= left_le ? key : left_entry;
    end else if (ctrl.rem_go && !lt) begin
      entry <= right_entry;
    end
  end

endmodule

/* rtl/smt_checker.sv */
// ----------------------------------------------------------------------------
// smt_checker: port-level checks for the sorted multiset table
// Watches the request and response channels and the reported results.
// ----------------------------------------------------------------------------
module smt_checker #(
  parameter int CAPACITY = 64
) (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input smt_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input smt_pkg::rsp_t rsp
);
  import smt_pkg::*;

  // a held response stays put
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // every accepted item shows its response on the next cycle
  a_rsp_follows: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> rsp_valid)
    else $error("no response after accepted item");

  // a refused insert only happens on a full table
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_FULL) |-> rsp.count == COUNT_W'(CAPACITY))
    else $error("insert refused below capacity");

  // a failed remove never reports a match
  a_miss_found: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_MISS) |-> !rsp.found)
    else $error("remove miss with found set");

  // count of entries never passes capacity (checked when CAPACITY <= 127)
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (CAPACITY > 127) || (int'(rsp.count) <= CAPACITY))
    else $error("count above capacity");

endmodule

bind sorted_multiset_table_top smt_checker #(.CAPACITY(CAPACITY)) u_smt_checker (.*);
